@@ rtl/core/station_result_voter_defines.svh @@
// Assertion macros shared by the voter checker.
`ifndef STATION_RESULT_VOTER_DEFINES_SVH
`define STATION_RESULT_VOTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVR_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SVR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/svr_pkg.sv @@
package svr_pkg;

  // Station store geometry
  localparam int STATIONS = 8;
  localparam int SLOT_W   = (STATIONS > 1) ? $clog2(STATIONS) : 1;
  localparam int CNT_W    = $clog2(STATIONS + 1);

  // Accumulator and divider widths
  localparam int SUM_W  = 16 + $clog2(STATIONS);
  localparam int WSUM_W = 8 + $clog2(STATIONS);
  localparam int DVD_W  = (SUM_W > WSUM_W + 15) ? SUM_W : WSUM_W + 15;
  localparam int DVS_W  = (CNT_W > WSUM_W) ? CNT_W : WSUM_W;
  localparam int QUO_W  = 16;
  localparam int MAJ_W  = SUM_W + 4;
  localparam int WCMP_W = WSUM_W + 4;

  localparam logic [15:0] SEV_ONE = 16'd32768;

  // Configuration port
  localparam int REG_W     = 64;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_STRATEGY = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_EXPECTED = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WEIGHTS  = 2'd3;

  // Command codes
  localparam logic [1:0] CMD_VERDICT = 2'd0;
  localparam logic [1:0] CMD_TICK    = 2'd1;
  localparam logic [1:0] CMD_CLEAR   = 2'd2;

  // Fusion strategies
  localparam logic [2:0] STRAT_ANY      = 3'd0;
  localparam logic [2:0] STRAT_ALL      = 3'd1;
  localparam logic [2:0] STRAT_MAJORITY = 3'd2;
  localparam logic [2:0] STRAT_WEIGHTED = 3'd3;
  localparam logic [2:0] STRAT_WORST    = 3'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  station;
    logic        pass_flag;
    logic [15:0] severity_in;
    logic [1:0]  level_in;
    logic [15:0] cycle_time_in;
  } verdict_t;

  typedef struct packed {
    logic        pass_out;
    logic [15:0] severity_out;
    logic [1:0]  level_out;
    logic [15:0] confidence_out;
    logic [15:0] cycle_time_out;
    logic        timed_out;
    logic [3:0]  stations_used;
  } result_t;

  // Weight of one station; stations past the packed word weigh 255.
  function automatic logic [7:0] weight_of(input logic [63:0] weights,
                                           input logic [SLOT_W-1:0] idx);
    logic [5:0] base;
    base = 6'(32'(idx) * 8);
    if (32'(idx) >= 8) return 8'hFF;
    return weights[base +: 8];
  endfunction

endpackage

@@ rtl/core/station_result_voter.sv @@
// Station result voter. Verdict, tick and clear commands are taken while busy is
// low. A command that completes a set, or a tick that expires the timer with
// verdicts stored, starts a fusion: busy covers a scan of every slot (one slot
// scanned per cycle through a single compare/accumulate unit), a setup step, the
// radix-2 divider when two or more verdicts are fused in majority mode, or in
// weighted mode with a nonzero weight total, and an output step. The fused result
// appears on result with done high for exactly one cycle, in the cycle busy falls;
// it cannot be held off, so the receiver must take it then. Configuration writes
// take effect at once and are meant for idle periods.
module station_result_voter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  svr_pkg::verdict_t                   verdict,
  output logic                                busy,
  output logic                                done,
  output svr_pkg::result_t                    result,
  input  logic                                wr_en,
  input  logic [svr_pkg::REG_IDX_W-1:0]       wr_index,
  input  logic [svr_pkg::REG_W-1:0]           wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state;

  // Configuration registers
  logic [2:0]  strategy;
  logic [3:0]  expected_count;
  logic [15:0] timeout_ticks;
  logic [63:0] station_weights;

  // Station store
  logic                       slot_valid      [svr_pkg::STATIONS];
  logic                       slot_pass       [svr_pkg::STATIONS];
  logic [15:0]                slot_severity   [svr_pkg::STATIONS];
  logic [1:0]                 slot_level      [svr_pkg::STATIONS];
  logic [15:0]                slot_cycle_time [svr_pkg::STATIONS];
  logic [svr_pkg::CNT_W-1:0]  stored_count;

  // Timer
  logic [15:0] timer_left;
  logic        timer_running;

  // Scan accumulators
  logic [svr_pkg::SLOT_W-1:0] scan_idx;
  logic [svr_pkg::CNT_W-1:0]  acc_n;
  logic [svr_pkg::CNT_W-1:0]  acc_okc;
  logic [svr_pkg::SUM_W-1:0]  acc_sevsum;
  logic [15:0]                acc_sevmax;
  logic [1:0]                 acc_worst_lv;
  logic [1:0]                 acc_lvmax;
  logic [1:0]                 acc_lvmin;
  logic [15:0]                acc_ctmax;
  logic [svr_pkg::WSUM_W-1:0] acc_wok;
  logic [svr_pkg::WSUM_W-1:0] acc_wtot;
  logic                       first_pass;
  logic [15:0]                first_sev;
  logic [1:0]                 first_lvl;
  logic                       timed;

  // Divider
  logic [svr_pkg::DVS_W-1:0]  div_rem;
  logic [svr_pkg::DVS_W-1:0]  div_divisor;
  logic [svr_pkg::QUO_W-1:0]  div_low;
  logic [3:0]                 div_cnt;

  // Command decode
  logic                       accept;
  logic                       station_ok;
  logic                       is_verdict;
  logic [svr_pkg::SLOT_W-1:0] slot_wr;
  logic [svr_pkg::CNT_W-1:0]  count_new;
  logic                       set_complete;
  logic [15:0]                timer_dec;
  logic                       fuse_timeout;
  logic                       clear_store;
  logic [15:0]                sev_sat;

  always_comb begin
    busy         = (state != ST_IDLE);
    accept       = start && !busy;
    station_ok   = (32'(verdict.station) < svr_pkg::STATIONS);
    is_verdict   = accept && (verdict.cmd == svr_pkg::CMD_VERDICT) && station_ok;
    slot_wr      = svr_pkg::SLOT_W'(verdict.station);
    count_new    = stored_count + {{(svr_pkg::CNT_W-1){1'b0}}, ~slot_valid[slot_wr]};
    set_complete = is_verdict && (32'(count_new) >= 32'(expected_count));
    timer_dec    = (timer_left != 16'd0) ? timer_left - 16'd1 : 16'd0;
    fuse_timeout = accept && (verdict.cmd == svr_pkg::CMD_TICK) && timer_running &&
                   (timer_dec == 16'd0) && (stored_count != '0);
    clear_store  = (accept && (verdict.cmd == svr_pkg::CMD_CLEAR)) || (state == ST_OUT);
    sev_sat      = (verdict.severity_in > svr_pkg::SEV_ONE) ? svr_pkg::SEV_ONE
                                                            : verdict.severity_in;
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy        <= svr_pkg::STRAT_ANY;
      expected_count  <= 4'd8;
      timeout_ticks   <= 16'd0;
      station_weights <= '1;
    end else if (wr_en) begin
      case (wr_index)
        svr_pkg::REG_STRATEGY: strategy        <= wr_data[2:0];
        svr_pkg::REG_EXPECTED: expected_count  <= wr_data[3:0];
        svr_pkg::REG_TIMEOUT:  timeout_ticks   <= wr_data[15:0];
        svr_pkg::REG_WEIGHTS:  station_weights <= wr_data;
        default: ;
      endcase
    end
  end

  // Track valid slots and their count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < svr_pkg::STATIONS; i++) slot_valid[i] <= 1'b0;
      stored_count <= '0;
    end else if (clear_store) begin
      for (int i = 0; i < svr_pkg::STATIONS; i++) slot_valid[i] <= 1'b0;
      stored_count <= '0;
    end else if (is_verdict) begin
      slot_valid[slot_wr] <= 1'b1;
      stored_count        <= count_new;
    end
  end

  // Store verdict payload
  always_ff @(posedge clk) begin
    if (is_verdict) begin
      slot_pass[slot_wr]       <= verdict.pass_flag;
      slot_severity[slot_wr]   <= sev_sat;
      slot_level[slot_wr]      <= verdict.level_in;
      slot_cycle_time[slot_wr] <= verdict.cycle_time_in;
    end
  end

  // Run the single-shot timeout
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_running <= 1'b0;
      timer_left    <= 16'd0;
    end else if (accept) begin
      case (verdict.cmd)
        svr_pkg::CMD_VERDICT: begin
          if (set_complete) begin
            timer_running <= 1'b0;
            timer_left    <= 16'd0;
          end else if (station_ok && !timer_running && (timeout_ticks != 16'd0)) begin
            timer_running <= 1'b1;
            timer_left    <= timeout_ticks;
          end
        end
        svr_pkg::CMD_TICK: begin
          if (timer_running) begin
            timer_left <= timer_dec;
            if (timer_dec == 16'd0) timer_running <= 1'b0;
          end
        end
        svr_pkg::CMD_CLEAR: begin
          timer_running <= 1'b0;
          timer_left    <= 16'd0;
        end
        default: ;
      endcase
    end
  end

  // Divider setup values
  logic                        need_div;
  logic [svr_pkg::DVD_W-1:0]   div_dividend;
  logic [svr_pkg::DVS_W-1:0]   div_divisor_in;
  logic [svr_pkg::DVS_W:0]     div_trial;
  logic                        div_qbit;
  logic [7:0]                  scan_w;
  logic                        multi;

  always_comb begin
    multi  = (32'(acc_n) >= 2);
    scan_w = svr_pkg::weight_of(station_weights, scan_idx);
    if (strategy == svr_pkg::STRAT_MAJORITY) begin
      need_div       = multi;
      div_dividend   = svr_pkg::DVD_W'(acc_sevsum);
      div_divisor_in = svr_pkg::DVS_W'(acc_n);
    end else begin
      need_div       = multi && (strategy == svr_pkg::STRAT_WEIGHTED) && (acc_wtot != '0);
      div_dividend   = svr_pkg::DVD_W'(acc_wok) << 15;
      div_divisor_in = svr_pkg::DVS_W'(acc_wtot);
    end
    div_trial = {div_rem, div_low[svr_pkg::QUO_W-1]};
    div_qbit  = (div_trial >= {1'b0, div_divisor});
  end

  // Sequence the scan, divide and output steps
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_OUT);
      case (state)
        ST_IDLE: begin
          if (set_complete || fuse_timeout) state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (32'(scan_idx) == svr_pkg::STATIONS - 1) state <= ST_PREP;
        end
        ST_PREP: begin
          state <= need_div ? ST_DIV : ST_OUT;
        end
        ST_DIV: begin
          if (div_cnt == 4'd15) state <= ST_OUT;
        end
        ST_OUT: begin
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Accumulate one slot per cycle
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      scan_idx     <= '0;
      acc_n        <= '0;
      acc_okc      <= '0;
      acc_sevsum   <= '0;
      acc_sevmax   <= 16'd0;
      acc_worst_lv <= 2'd0;
      acc_lvmax    <= 2'd0;
      acc_lvmin    <= 2'd3;
      acc_ctmax    <= 16'd0;
      acc_wok      <= '0;
      acc_wtot     <= '0;
      timed        <= fuse_timeout;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + svr_pkg::SLOT_W'(1);
      if (slot_valid[scan_idx]) begin
        if (acc_n == '0) begin
          first_pass <= slot_pass[scan_idx];
          first_sev  <= slot_severity[scan_idx];
          first_lvl  <= slot_level[scan_idx];
        end
        acc_n      <= acc_n + svr_pkg::CNT_W'(1);
        acc_wtot   <= acc_wtot + svr_pkg::WSUM_W'(scan_w);
        acc_sevsum <= acc_sevsum + svr_pkg::SUM_W'(slot_severity[scan_idx]);
        if (slot_pass[scan_idx]) begin
          acc_okc <= acc_okc + svr_pkg::CNT_W'(1);
          acc_wok <= acc_wok + svr_pkg::WSUM_W'(scan_w);
        end
        if (slot_severity[scan_idx] > acc_sevmax) begin
          acc_sevmax   <= slot_severity[scan_idx];
          acc_worst_lv <= slot_level[scan_idx];
        end
        if (slot_level[scan_idx] > acc_lvmax) acc_lvmax <= slot_level[scan_idx];
        if (slot_level[scan_idx] < acc_lvmin) acc_lvmin <= slot_level[scan_idx];
        if (slot_cycle_time[scan_idx] > acc_ctmax) acc_ctmax <= slot_cycle_time[scan_idx];
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state == ST_PREP) begin
      div_cnt     <= 4'd0;
      div_divisor <= div_divisor_in;
      div_rem     <= svr_pkg::DVS_W'(div_dividend >> 16);
      div_low     <= need_div ? div_dividend[svr_pkg::QUO_W-1:0] : '0;
    end else if (state == ST_DIV) begin
      div_cnt <= div_cnt + 4'd1;
      div_rem <= div_qbit ? svr_pkg::DVS_W'(div_trial - {1'b0, div_divisor})
                          : div_trial[svr_pkg::DVS_W-1:0];
      div_low <= {div_low[svr_pkg::QUO_W-2:0], div_qbit};
    end
  end

  // Combine accumulators into the fused verdict
  svr_pkg::result_t             fused;
  logic [svr_pkg::MAJ_W-1:0]    maj_t;
  logic [svr_pkg::MAJ_W-1:0]    maj_b;
  logic [svr_pkg::WCMP_W-1:0]   wk;
  logic [svr_pkg::WCMP_W-1:0]   wt;
  logic                         all_ok;

  always_comb begin
    maj_t  = svr_pkg::MAJ_W'(acc_sevsum) * svr_pkg::MAJ_W'(10);
    maj_b  = svr_pkg::MAJ_W'(acc_n) * svr_pkg::MAJ_W'(svr_pkg::SEV_ONE);
    wk     = svr_pkg::WCMP_W'(acc_wok);
    wt     = svr_pkg::WCMP_W'(acc_wtot);
    all_ok = (acc_okc == acc_n);

    fused                = '0;
    fused.cycle_time_out = acc_ctmax;
    fused.timed_out      = timed;
    fused.stations_used  = 4'(acc_n);
    fused.severity_out   = acc_sevmax;

    if (!multi) begin
      fused.pass_out     = first_pass;
      fused.severity_out = first_sev;
      fused.level_out    = first_lvl;
    end else begin
      case (strategy)
        svr_pkg::STRAT_ALL: begin
          fused.pass_out  = (acc_okc != '0);
          fused.level_out = (acc_okc != '0) ? 2'd0 : acc_lvmin;
        end
        svr_pkg::STRAT_MAJORITY: begin
          fused.pass_out     = ({acc_okc, 1'b0} >= {1'b0, acc_n});
          fused.severity_out = div_low;
          if (maj_t < svr_pkg::MAJ_W'(3) * maj_b)      fused.level_out = 2'd0;
          else if (maj_t < svr_pkg::MAJ_W'(5) * maj_b) fused.level_out = 2'd1;
          else if (maj_t < svr_pkg::MAJ_W'(8) * maj_b) fused.level_out = 2'd2;
          else                                         fused.level_out = 2'd3;
        end
        svr_pkg::STRAT_WEIGHTED: begin
          fused.pass_out       = (svr_pkg::WCMP_W'(2) * wk > wt);
          fused.confidence_out = div_low;
          if (svr_pkg::WCMP_W'(5) * wk > svr_pkg::WCMP_W'(4) * wt)
            fused.level_out = 2'd0;
          else if (svr_pkg::WCMP_W'(5) * wk > svr_pkg::WCMP_W'(3) * wt)
            fused.level_out = 2'd1;
          else if (svr_pkg::WCMP_W'(10) * wk > svr_pkg::WCMP_W'(3) * wt)
            fused.level_out = 2'd2;
          else
            fused.level_out = 2'd3;
        end
        svr_pkg::STRAT_WORST: begin
          fused.pass_out  = all_ok;
          fused.level_out = acc_worst_lv;
        end
        default: begin
          fused.pass_out  = all_ok;
          fused.level_out = acc_lvmax;
        end
      endcase
    end
  end

  // Hold the result beat for its strobe
  always_ff @(posedge clk) begin
    if (state == ST_OUT) result <= fused;
  end

endmodule

@@ rtl/core/svr_checker.sv @@
`include "station_result_voter_defines.svh"

module svr_checker (
  input logic             clk,
  input logic             rst,
  input logic             busy,
  input logic             done,
  input svr_pkg::result_t result
);

  // Result beat lasts one cycle and lands as the block goes idle
  `SVR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result beat held past one cycle")
  `SVR_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result beat while still busy")
  `SVR_ASSERT_NOW(a_done_after_fuse, clk, rst, done, $past(busy), "result beat without fusion")

  // Fused beat carries a sane station count and Q1.15 values
  `SVR_ASSERT_NOW(a_used_range, clk, rst, done, (result.stations_used != 4'd0) && (32'(result.stations_used) <= svr_pkg::STATIONS), "station count out of range")
  `SVR_ASSERT_NOW(a_q15_range, clk, rst, done, (result.severity_out <= svr_pkg::SEV_ONE) && (result.confidence_out <= svr_pkg::SEV_ONE), "Q1.15 value above one")

endmodule

bind station_result_voter svr_checker u_svr_checker (.*);

@@ verif/tb_station_result_voter.sv @@
`timescale 1ns / 100ps

module tb_station_result_voter;
  import svr_pkg::*;

  localparam int CLK_PERIOD      = 2;
  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 32;     // covers the longest fusion
  localparam int DRAIN_LIMIT     = 1000;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int MAX_PRINTED     = 40;
  localparam int PHASES          = 16;
  localparam int PHASE_BEATS     = 115;
  localparam int BURST_LEN       = 24;

  // Codes the package leaves unnamed
  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam logic [2:0] STRAT_SPARE = 3'd7;

  typedef logic [15:0] field_set_t [7];

  typedef struct {
    bit                    is_write;
    logic [REG_IDX_W-1:0]  idx;
    logic [REG_W-1:0]      data;
    verdict_t              beat;
    bit                    typed;
    result_t               want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  verdict_t              verdict = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  wr_en = 1'b0;
  logic [REG_IDX_W-1:0]  wr_index = '0;
  logic [REG_W-1:0]      wr_data = '0;

  // Register shadow, at reset values
  logic [2:0]  cfg_strategy = STRAT_ANY;
  logic [3:0]  cfg_expected = 4'd8;
  logic [15:0] cfg_timeout  = 16'd0;
  logic [63:0] cfg_weights  = '1;

  // Station store and timer shadow
  bit [STATIONS-1:0] st_valid = '0;
  bit [STATIONS-1:0] st_ok    = '0;
  logic [15:0]       st_sev [STATIONS];
  logic [1:0]        st_lvl [STATIONS];
  logic [15:0]       st_ct  [STATIONS];
  int unsigned       tmr_left = 0;
  bit                tmr_on   = 1'b0;

  result_t     expected_fusions [$];
  int          mismatches   = 0;
  int          beats_sent   = 0;
  int          fusions_seen = 0;
  int          timed_seen   = 0;
  int          idle_cycles  = 0;
  bit          burst        = 1'b0;
  string       field_names [7] = '{"pass_out", "severity_out", "level_out", "confidence_out",
                                   "cycle_time_out", "timed_out", "stations_used"};

  station_result_voter dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .verdict  (verdict),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Fuse the stored verdicts and empty the store
  task automatic fuse_store(input bit timed, output result_t r);
    int unsigned n, okc, sev_max, sev_sum, ct_max, lv_max, lv_min, worst_lv, worst_sev, first;
    longint unsigned w, w_ok, w_tot, ten_sum, sev_unit;
    bit          ok_o;
    int unsigned sev_o, lv_o, conf_o;
    n = 0; okc = 0; sev_max = 0; sev_sum = 0; ct_max = 0;
    lv_max = 0; lv_min = 3; worst_lv = 0; worst_sev = 0; first = STATIONS;
    w_ok = 0; w_tot = 0; conf_o = 0;
    // walk stored slots in station order
    for (int i = 0; i < STATIONS; i++) begin
      if (!st_valid[i]) continue;
      if (first == STATIONS) first = i;
      n++;
      w = (i < 8) ? longint'(cfg_weights[8*i +: 8]) : 255;
      w_tot += w;
      if (st_ok[i]) begin
        okc++;
        w_ok += w;
      end
      sev_sum += st_sev[i];
      if (st_sev[i] > sev_max) sev_max = st_sev[i];
      if (st_sev[i] > worst_sev) begin
        worst_sev = st_sev[i];
        worst_lv = st_lvl[i];
      end
      if (st_lvl[i] > lv_max) lv_max = st_lvl[i];
      if (st_lvl[i] < lv_min) lv_min = st_lvl[i];
      if (st_ct[i] > ct_max) ct_max = st_ct[i];
    end

    if (n == 1) begin
      // lone verdict passes through
      ok_o = st_ok[first];
      sev_o = st_sev[first];
      lv_o = st_lvl[first];
    end else begin
      case (cfg_strategy)
        STRAT_ALL: begin
          ok_o = (okc > 0);
          sev_o = sev_max;
          lv_o = (okc > 0) ? 0 : lv_min;
        end
        STRAT_MAJORITY: begin
          ok_o = (okc >= n - okc);
          sev_o = sev_sum / n;
          ten_sum = longint'(sev_sum) * 10;
          sev_unit = longint'(n) * longint'(SEV_ONE);
          if (ten_sum < 3 * sev_unit) lv_o = 0;
          else if (ten_sum < 5 * sev_unit) lv_o = 1;
          else if (ten_sum < 8 * sev_unit) lv_o = 2;
          else lv_o = 3;
        end
        STRAT_WEIGHTED: begin
          ok_o = (2 * w_ok > w_tot);
          sev_o = sev_max;
          conf_o = (w_tot != 0) ? int'((w_ok * longint'(SEV_ONE)) / w_tot) : 0;
          if (5 * w_ok > 4 * w_tot) lv_o = 0;
          else if (5 * w_ok > 3 * w_tot) lv_o = 1;
          else if (10 * w_ok > 3 * w_tot) lv_o = 2;
          else lv_o = 3;
        end
        STRAT_WORST: begin
          ok_o = (okc == n);
          sev_o = sev_max;
          lv_o = worst_lv;
        end
        default: begin
          // any-fail, also for unassigned strategy codes
          ok_o = (okc == n);
          sev_o = sev_max;
          lv_o = lv_max;
        end
      endcase
    end

    r.pass_out       = ok_o;
    r.severity_out   = 16'(sev_o);
    r.level_out      = 2'(lv_o);
    r.confidence_out = 16'(conf_o);
    r.cycle_time_out = 16'(ct_max);
    r.timed_out      = timed;
    r.stations_used  = 4'(n);
    st_valid = '0;
    st_ok    = '0;
  endtask

  // Advance the store and timer by one accepted beat
  task automatic apply_beat(input verdict_t b, output bit fired, output result_t r);
    fired = 1'b0;
    r = '0;
    case (b.cmd)
      CMD_VERDICT: begin
        if (b.station < STATIONS) begin
          st_valid[b.station] = 1'b1;
          st_ok[b.station]    = b.pass_flag;
          st_sev[b.station]   = (b.severity_in > SEV_ONE) ? SEV_ONE : b.severity_in;
          st_lvl[b.station]   = b.level_in;
          st_ct[b.station]    = b.cycle_time_in;
          if ($countones(st_valid) >= cfg_expected) begin
            tmr_on = 1'b0;
            tmr_left = 0;
            fuse_store(1'b0, r);
            fired = 1'b1;
          end else if (!tmr_on && cfg_timeout != 0) begin
            tmr_on = 1'b1;
            tmr_left = cfg_timeout;
          end
        end
      end
      CMD_TICK: begin
        if (tmr_on) begin
          if (tmr_left > 0) tmr_left--;
          if (tmr_left == 0) begin
            tmr_on = 1'b0;
            if (st_valid != '0) begin
              fuse_store(1'b1, r);
              fired = 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        st_valid = '0;
        st_ok = '0;
        tmr_on = 1'b0;
        tmr_left = 0;
      end
      default: ;
    endcase
  endtask

  // Present one beat after a random gap, none in a burst; ends on the falling edge after acceptance
  task automatic send_beat(input verdict_t b, input bit typed, input result_t want);
    int unsigned gap;
    bit          fired;
    result_t     r;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start = 1'b1;
    verdict = b;
    do @(posedge clk); while (busy !== 1'b0);
    beats_sent++;
    apply_beat(b, fired, r);
    if (typed) expected_fusions.push_back(want);
    else if (fired) expected_fusions.push_back(r);
    @(negedge clk);
  endtask

  // Hold off until every fusion has come back and the block is quiet
  task automatic settle();
    int waited;
    start = 1'b0;
    waited = 0;
    while (expected_fusions.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_fusions.size() != 0) begin
      report($sformatf("%0d fused results never arrived", expected_fusions.size()));
      expected_fusions.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = data;
    case (idx)
      REG_STRATEGY: cfg_strategy = data[2:0];
      REG_EXPECTED: cfg_expected = data[3:0];
      REG_TIMEOUT:  cfg_timeout  = data[15:0];
      REG_WEIGHTS:  cfg_weights  = data;
      default: ;
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  // Random beat: mostly verdicts that fill missing stations, some ticks and noise
  function automatic verdict_t draw_beat(input bit timer_mode);
    verdict_t    b;
    int unsigned roll;
    b.station = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0 && st_valid != '1) begin
      while (st_valid[b.station]) b.station = 3'($urandom_range(0, 7));
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) b.cmd = CMD_SPARE;
    else if (roll < 6) b.cmd = CMD_CLEAR;
    else if (roll < (timer_mode ? 32 : 12)) b.cmd = CMD_TICK;
    else b.cmd = CMD_VERDICT;
    b.pass_flag = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: b.severity_in = 16'd0;
      1: b.severity_in = SEV_ONE;
      2: b.severity_in = 16'($urandom_range(32769, 65535));
      3: b.severity_in = 16'($urandom_range(0, 255));
      default: b.severity_in = 16'($urandom_range(0, 32768));
    endcase
    b.level_in = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: b.cycle_time_in = 16'd0;
      1: b.cycle_time_in = 16'hFFFF;
      default: b.cycle_time_in = 16'($urandom);
    endcase
    return b;
  endfunction

  function automatic field_set_t fields_of(input result_t r);
    field_set_t f;
    f = '{16'(r.pass_out), r.severity_out, 16'(r.level_out), r.confidence_out,
          r.cycle_time_out, 16'(r.timed_out), 16'(r.stations_used)};
    return f;
  endfunction

  function automatic plan_row_t reg_row(input logic [REG_IDX_W-1:0] idx,
                                        input logic [REG_W-1:0] data);
    plan_row_t row;
    row.is_write = 1'b1;
    row.idx = idx;
    row.data = data;
    row.beat = '0;
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t beat_row(input logic [1:0] cmd, input logic [2:0] st,
                                         input bit ok, input logic [15:0] sev,
                                         input logic [1:0] lvl, input logic [15:0] ct);
    plan_row_t row;
    row.is_write = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.beat = '{cmd: cmd, station: st, pass_flag: ok, severity_in: sev,
                 level_in: lvl, cycle_time_in: ct};
    row.typed = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known(input plan_row_t row, input bit ok,
                                      input logic [15:0] sev, input logic [1:0] lvl,
                                      input logic [15:0] conf, input logic [15:0] ct,
                                      input bit timed, input logic [3:0] used);
    row.typed = 1'b1;
    row.want = '{pass_out: ok, severity_out: sev, level_out: lvl, confidence_out: conf,
                 cycle_time_out: ct, timed_out: timed, stations_used: used};
    return row;
  endfunction

  // Compare each fused beat with the oldest expectation
  always @(posedge clk) begin : fusion_check
    result_t    want;
    field_set_t got_f, want_f;
    if (!rst && done === 1'b1) begin
      if (expected_fusions.size() == 0) begin
        report("fused result with none expected");
      end else begin
        want = expected_fusions.pop_front();
        got_f = fields_of(result);
        want_f = fields_of(want);
        for (int k = 0; k < 7; k++) begin
          if (got_f[k] !== want_f[k])
            report($sformatf("%s got %0d, expected %0d", field_names[k], got_f[k], want_f[k]));
        end
        fusions_seen++;
        if (want.timed_out) timed_seen++;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || done === 1'b1 || wr_en) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    plan_row_t   plan [$];
    bit          prev_write;
    logic [2:0]  ph_strat;
    logic [3:0]  ph_expected;
    logic [15:0] ph_timeout;
    logic [63:0] ph_weights;
    int unsigned roll;

    // lone verdict with saturated severity and all-ones fields
    plan.push_back(reg_row(REG_EXPECTED, 64'd1));
    plan.push_back(known(beat_row(CMD_VERDICT, 3'd7, 1'b1, 16'hFFFF, 2'd3, 16'hFFFF),
                         1'b1, SEV_ONE, 2'd3, 16'd0, 16'hFFFF, 1'b0, 4'd1));
    // zero expected count: every verdict completes a set
    plan.push_back(reg_row(REG_EXPECTED, 64'd0));
    plan.push_back(known(beat_row(CMD_VERDICT, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0),
                         1'b0, 16'd0, 2'd0, 16'd0, 16'd0, 1'b0, 4'd1));
    // timer expiry on a partial set, then a stopped-timer tick and an unused code
    plan.push_back(reg_row(REG_EXPECTED, 64'd8));
    plan.push_back(reg_row(REG_TIMEOUT, 64'd2));
    plan.push_back(beat_row(CMD_VERDICT, 3'd3, 1'b0, 16'd32769, 2'd2, 16'd1234));
    plan.push_back(beat_row(CMD_TICK, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0));
    plan.push_back(known(beat_row(CMD_TICK, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0),
                         1'b0, SEV_ONE, 2'd2, 16'd0, 16'd1234, 1'b1, 4'd1));
    plan.push_back(beat_row(CMD_TICK, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0));
    plan.push_back(beat_row(CMD_SPARE, 3'd5, 1'b1, 16'hA5A5, 2'd2, 16'h5A5A));
    // clear drops the store and stops the timer
    plan.push_back(beat_row(CMD_VERDICT, 3'd1, 1'b1, 16'd500, 2'd1, 16'd9));
    plan.push_back(beat_row(CMD_CLEAR, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0));
    plan.push_back(beat_row(CMD_TICK, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0));
    plan.push_back(beat_row(CMD_TICK, 3'd0, 1'b0, 16'd0, 2'd0, 16'd0));
    // weighted with a zero weight total
    plan.push_back(reg_row(REG_TIMEOUT, 64'd0));
    plan.push_back(reg_row(REG_EXPECTED, 64'd2));
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_WEIGHTED)));
    plan.push_back(reg_row(REG_WEIGHTS, 64'd0));
    plan.push_back(beat_row(CMD_VERDICT, 3'd0, 1'b1, 16'd100, 2'd1, 16'd5));
    plan.push_back(known(beat_row(CMD_VERDICT, 3'd5, 1'b1, 16'd200, 2'd0, 16'd7),
                         1'b0, 16'd200, 2'd3, 16'd0, 16'd7, 1'b0, 4'd2));
    // weighted with full weights
    plan.push_back(reg_row(REG_WEIGHTS, '1));
    plan.push_back(beat_row(CMD_VERDICT, 3'd2, 1'b1, 16'd300, 2'd1, 16'd1));
    plan.push_back(beat_row(CMD_VERDICT, 3'd4, 1'b0, SEV_ONE, 2'd3, 16'd2));
    // majority
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_MAJORITY)));
    plan.push_back(beat_row(CMD_VERDICT, 3'd0, 1'b1, SEV_ONE, 2'd0, 16'd0));
    plan.push_back(beat_row(CMD_VERDICT, 3'd7, 1'b0, 16'd0, 2'd3, 16'hFFFF));
    // all-fail
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_ALL)));
    plan.push_back(beat_row(CMD_VERDICT, 3'd1, 1'b0, 16'd10, 2'd2, 16'd3));
    plan.push_back(beat_row(CMD_VERDICT, 3'd6, 1'b0, 16'd20, 2'd1, 16'd4));
    // worst severity: a tie keeps the first station's level
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_WORST)));
    plan.push_back(beat_row(CMD_VERDICT, 3'd2, 1'b1, 16'd40, 2'd1, 16'd8));
    plan.push_back(beat_row(CMD_VERDICT, 3'd3, 1'b0, 16'd40, 2'd3, 16'd6));
    // unassigned strategy code behaves as any-fail
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_SPARE)));
    plan.push_back(beat_row(CMD_VERDICT, 3'd4, 1'b1, 16'd5, 2'd2, 16'd11));
    plan.push_back(beat_row(CMD_VERDICT, 3'd5, 1'b1, 16'd6, 2'd1, 16'd12));
    // worst severity with every severity zero gives level 0
    plan.push_back(reg_row(REG_STRATEGY, 64'(STRAT_WORST)));
    plan.push_back(beat_row(CMD_VERDICT, 3'd0, 1'b1, 16'd0, 2'd3, 16'd3));
    plan.push_back(known(beat_row(CMD_VERDICT, 3'd1, 1'b1, 16'd0, 2'd2, 16'd4),
                         1'b1, 16'd0, 2'd0, 16'd0, 16'd4, 1'b0, 4'd2));

    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // walk the directed table; settle before each group of register writes
    prev_write = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!prev_write) settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].beat, plan[i].typed, plan[i].want);
      end
      prev_write = plan[i].is_write;
    end

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      ph_strat = (p < 8) ? 3'(p) : (p == 8) ? STRAT_WEIGHTED :
                 (p == 9) ? STRAT_MAJORITY : 3'($urandom_range(0, 7));
      ph_expected = 4'($urandom_range(2, 8));
      if ($urandom_range(0, 4) == 0) ph_expected = 4'($urandom_range(0, 15));
      roll = $urandom_range(0, 9);
      ph_timeout = (roll < 3) ? 16'd0 : (roll < 9) ? 16'($urandom_range(1, 20)) : 16'hFFFF;
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 3))
          0: ph_weights[8*k +: 8] = 8'h00;
          1: ph_weights[8*k +: 8] = 8'hFF;
          default: ph_weights[8*k +: 8] = 8'($urandom);
        endcase
      end
      case (p)
        0: begin
          ph_expected = 4'd8;
          ph_timeout = 16'd0;
          ph_weights = '1;
        end
        1: begin
          ph_expected = 4'd0;
          ph_timeout = 16'd3;
        end
        2: begin
          ph_expected = 4'd15;
          ph_timeout = 16'($urandom_range(1, 6));
        end
        3: begin
          ph_expected = 4'd4;
          ph_timeout = 16'd0;
          ph_weights = '0;
        end
        4: begin
          ph_expected = 4'd8;
          ph_timeout = 16'hFFFF;
          ph_weights = '1;
        end
        5: begin
          ph_expected = 4'd1;
          ph_timeout = 16'd1;
        end
        default: ;
      endcase
      // an unreachable set count needs a short timer to fuse at all
      if (ph_expected > STATIONS && (ph_timeout == 0 || ph_timeout > 20))
        ph_timeout = 16'($urandom_range(1, 20));

      settle();
      write_reg(REG_STRATEGY, 64'(ph_strat));
      write_reg(REG_EXPECTED, 64'(ph_expected));
      write_reg(REG_TIMEOUT, 64'(ph_timeout));
      write_reg(REG_WEIGHTS, ph_weights);

      for (int i = 0; i < PHASE_BEATS; i++) begin
        burst = (i < BURST_LEN) && (p % 2 == 0);
        send_beat(draw_beat(ph_timeout != 0), 1'b0, '0);
      end
      burst = 1'b0;
    end

    settle();
    $display("Sent %0d beats over %0d random register phases plus the directed table.",
             beats_sent, PHASES);
    $display("Checked %0d fused results, %0d of them after a timeout; %0d mismatches.",
             fusions_seen, timed_seen, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
